// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the bar ballistics block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the condition post holds in every cycle in which pre holds.
`define SBB_ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
		else $error("implication check failed");

// Checks that the condition never holds while out of reset.
`define SBB_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");

`endif

// ===== rtl/sbb_pkg.sv =====
// Package with the types, constants and register codes of the bar ballistics block.
package sbb_pkg;

	// Defaults of the top level parameters.
	localparam int BAND_COUNT_DEFAULT  = 12;
	localparam int BLOCK_PITCH_DEFAULT = 7;

	// Fixed field widths.
	localparam int BAND_W   = 4;
	localparam int LEVEL_W  = 8;
	localparam int HEIGHT_W = 7;
	localparam int COEF_W   = 8;
	localparam int HOLD_W   = 4;
	localparam int SMOOTH_W = 15;
	localparam int FRAC_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Register reset values.
	localparam logic [COEF_W-1:0]   RISE_RESET  = 8'd90;
	localparam logic [COEF_W-1:0]   FALL_RESET  = 8'd38;
	localparam logic [HOLD_W-1:0]   HOLD_RESET  = 4'd12;
	localparam logic [HEIGHT_W-1:0] LIMIT_RESET = 7'd84;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RISE  = 2'd0,
		CFG_FALL  = 2'd1,
		CFG_HOLD  = 2'd2,
		CFG_LIMIT = 2'd3
	} cfg_idx_t;

	// One band's stored state, as kept in the state memory.
	typedef struct packed {
		logic [SMOOTH_W-1:0] smooth;
		logic [HEIGHT_W-1:0] shown;
		logic [HEIGHT_W-1:0] peak;
		logic [HOLD_W-1:0]   hold;
	} entry_t;

	// Context that travels with an item down the pipeline.
	typedef struct packed {
		logic [BAND_W-1:0] band;
		logic              in_range;
		entry_t            ent;
	} ctx_t;

endpackage

// ===== rtl/sbb_ram.sv =====
// Generic single write port, single read port RAM with a registered read.
module sbb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/spectrum_bar_ballistics_top.sv =====
// Top level of the spectrum bar ballistics block: smoothing and peak hold per band.
// An input transfer loads stage one, and the item then moves through stages two to six into
// the output register. Throughput: one band level per cycle while no level names a band
// still held in one of the six stages; such a level waits until that band's state is
// written back. A result that is not taken halts the whole pipeline.
// Reset: registers take their default values and all per-band valid bits clear, so every band
// reads as zero state; there is no clearing pass and the block is ready right after reset.
`include "assert_macros.svh"

module spectrum_bar_ballistics_top #(
	parameter int BAND_COUNT  = sbb_pkg::BAND_COUNT_DEFAULT,
	parameter int BLOCK_PITCH = sbb_pkg::BLOCK_PITCH_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration write port.
	input  logic                            cfg_we,
	input  logic [sbb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [sbb_pkg::CFG_DATA_W-1:0]  cfg_data,
	// Input channel.
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [sbb_pkg::BAND_W-1:0]      band_number,
	input  logic [sbb_pkg::LEVEL_W-1:0]     band_level,
	// Result channel.
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [sbb_pkg::BAND_W-1:0]      result_band,
	output logic [sbb_pkg::HEIGHT_W-1:0]    bar_height,
	output logic [sbb_pkg::HEIGHT_W-1:0]    prior_bar_height,
	output logic [sbb_pkg::HEIGHT_W-1:0]    peak_height,
	output logic [sbb_pkg::HEIGHT_W-1:0]    prior_peak_height,
	output logic                            peak_moved
);

	// Address width of the state memory.
	localparam int AW = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
	// Division by the block pitch is done as a multiplication by a rounded-up reciprocal.
	// With heights below 128 and a pitch of at most 16 the quotient is exact for 16 fraction bits.
	localparam int RECIP_SH = 16;
	localparam int RECIP    = ((1 << RECIP_SH) + BLOCK_PITCH - 1) / BLOCK_PITCH;
	localparam int QPROD_W  = sbb_pkg::HEIGHT_W + RECIP_SH + 1;
	localparam int BPROD_W  = sbb_pkg::HEIGHT_W + 5;
	localparam int PROD_W   = sbb_pkg::SMOOTH_W + sbb_pkg::COEF_W;

	// ------------------------------------------------------------------
	// Configuration registers. Writes must come only while the block is idle; it does not check.
	// ------------------------------------------------------------------
	logic [sbb_pkg::COEF_W-1:0]   rise_q;
	logic [sbb_pkg::COEF_W-1:0]   fall_q;
	logic [sbb_pkg::HOLD_W-1:0]   hold_frames_q;
	logic [sbb_pkg::HEIGHT_W-1:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_q        <= sbb_pkg::RISE_RESET;
			fall_q        <= sbb_pkg::FALL_RESET;
			hold_frames_q <= sbb_pkg::HOLD_RESET;
			limit_q       <= sbb_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			case (sbb_pkg::cfg_idx_t'(cfg_index))
				sbb_pkg::CFG_RISE:  rise_q        <= cfg_data;
				sbb_pkg::CFG_FALL:  fall_q        <= cfg_data;
				sbb_pkg::CFG_HOLD:  hold_frames_q <= cfg_data[sbb_pkg::HOLD_W-1:0];
				sbb_pkg::CFG_LIMIT: limit_q       <= cfg_data[sbb_pkg::HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline registers.
	// ------------------------------------------------------------------
	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [sbb_pkg::BAND_W-1:0]    band_s1;
	logic                          inr_s1;
	logic                          ent_vld_s1;
	logic [sbb_pkg::LEVEL_W-1:0]   level_s1;
	sbb_pkg::ctx_t                 ctx_s2, ctx_s3, ctx_s4, ctx_s5, ctx_s6;
	logic                          rise_s2, rise_s3;
	logic [sbb_pkg::SMOOTH_W-1:0]  diff_s2;
	logic [sbb_pkg::COEF_W-1:0]    coef_s2;
	logic [PROD_W-1:0]             prod_s3;
	logic [sbb_pkg::SMOOTH_W-1:0]  snew_s4, snew_s5, snew_s6;
	logic [sbb_pkg::HEIGHT_W-1:0]  raw_s5;
	logic [sbb_pkg::HEIGHT_W-1:0]  quot_s6;

	logic                          out_valid_q;
	logic [sbb_pkg::BAND_W-1:0]    result_band_q;
	logic [sbb_pkg::HEIGHT_W-1:0]  bar_q, prior_bar_q, peak_q, prior_peak_q;
	logic                          moved_q;

	// The whole pipeline moves together; it only halts when the output register is full and
	// its result is not taken. The stages in front of it hold items meanwhile.
	logic adv;
	logic hazard;
	logic accept;
	assign adv    = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	// Input band, extended to the memory address width, and its range check.
	logic [sbb_pkg::BAND_W+AW-1:0] band_ext;
	logic [AW-1:0]                 in_addr;
	logic                          in_range;
	assign band_ext = {{AW{1'b0}}, band_number};
	assign in_addr  = band_ext[AW-1:0];
	assign in_range = 32'(band_number) < 32'(BAND_COUNT);

	// A band whose state is still being updated in the pipeline must not be read again
	// until the write back has happened; the read would otherwise return stale state.
	assign hazard =
		(vld_s1 && inr_s1 && (band_s1 == band_number)) ||
		(vld_s2 && ctx_s2.in_range && (ctx_s2.band == band_number)) ||
		(vld_s3 && ctx_s3.in_range && (ctx_s3.band == band_number)) ||
		(vld_s4 && ctx_s4.in_range && (ctx_s4.band == band_number)) ||
		(vld_s5 && ctx_s5.in_range && (ctx_s5.band == band_number)) ||
		(vld_s6 && ctx_s6.in_range && (ctx_s6.band == band_number));
	assign in_ready = adv && !hazard;

	// ------------------------------------------------------------------
	// State memory and its per-band valid bits. An entry never written reads as zero.
	// ------------------------------------------------------------------
	logic [BAND_COUNT-1:0] valid_q;
	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	sbb_pkg::entry_t       ram_wdata;
	logic                  ram_re;
	sbb_pkg::entry_t       ram_rdata;
	logic [sbb_pkg::BAND_W+AW-1:0] wband_ext;

	assign ram_re    = accept && in_range;
	assign wband_ext = {{AW{1'b0}}, ctx_s6.band};
	assign ram_waddr = wband_ext[AW-1:0];
	assign ram_we    = adv && vld_s6 && ctx_s6.in_range;

	sbb_ram #(
		.WIDTH ($bits(sbb_pkg::entry_t)),
		.DEPTH (BAND_COUNT)
	) u_state_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ram_we) begin
			valid_q[ram_waddr] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: state read data arrives; form the target and the distance to it.
	// ------------------------------------------------------------------
	sbb_pkg::entry_t               ent_s1;
	logic [sbb_pkg::HEIGHT_W-1:0]  tgt_px_s1;
	logic [sbb_pkg::SMOOTH_W-1:0]  target_s1;
	logic                          rising_s1;

	assign ent_s1    = ent_vld_s1 ? ram_rdata : '0;
	assign tgt_px_s1 = (level_s1 > {1'b0, limit_q}) ? limit_q
		: level_s1[sbb_pkg::HEIGHT_W-1:0];
	assign target_s1 = {tgt_px_s1, {sbb_pkg::FRAC_W{1'b0}}};
	assign rising_s1 = target_s1 > ent_s1.smooth;

	// ------------------------------------------------------------------
	// Stage 4 and 5 arithmetic: apply the scaled step, then round to pixels and clamp.
	// Falling steps round the magnitude up, which floors the signed step.
	// ------------------------------------------------------------------
	logic [PROD_W:0]               dec_sum_s3;
	logic [sbb_pkg::SMOOTH_W-1:0]  inc_s3, dec_s3;
	logic [sbb_pkg::SMOOTH_W:0]    round_sum_s4;
	logic [sbb_pkg::LEVEL_W-1:0]   raw8_s4;
	logic [QPROD_W-1:0]            qprod_s5;

	assign inc_s3       = prod_s3[sbb_pkg::FRAC_W +: sbb_pkg::SMOOTH_W];
	assign dec_sum_s3   = (PROD_W+1)'(prod_s3) + (PROD_W+1)'(255);
	assign dec_s3       = dec_sum_s3[sbb_pkg::FRAC_W +: sbb_pkg::SMOOTH_W];
	assign round_sum_s4 = (sbb_pkg::SMOOTH_W+1)'(snew_s4) + (sbb_pkg::SMOOTH_W+1)'(128);
	assign raw8_s4      = round_sum_s4[sbb_pkg::FRAC_W +: sbb_pkg::LEVEL_W];
	assign qprod_s5     = QPROD_W'(raw_s5) * QPROD_W'(RECIP);

	// ------------------------------------------------------------------
	// Stage 6: snap to whole blocks and run the peak hold and decay.
	// ------------------------------------------------------------------
	logic [BPROD_W-1:0]            bprod_s6;
	logic [sbb_pkg::HEIGHT_W-1:0]  bar_s6;
	logic [sbb_pkg::HEIGHT_W-1:0]  gap_s6, drop_s6, pk_next_s6, pk_s6;
	logic [sbb_pkg::HOLD_W-1:0]    hold_next_s6;
	logic [sbb_pkg::HEIGHT_W-1:0]  old_bar_s6, old_peak_s6;

	assign bprod_s6 = BPROD_W'(quot_s6) * BPROD_W'(BLOCK_PITCH);
	assign bar_s6   = bprod_s6[sbb_pkg::HEIGHT_W-1:0];
	assign gap_s6   = ctx_s6.ent.peak - bar_s6;

	always_comb begin
		drop_s6      = {2'b00, gap_s6[sbb_pkg::HEIGHT_W-1:2]};
		pk_next_s6   = ctx_s6.ent.peak;
		hold_next_s6 = ctx_s6.ent.hold;
		if (drop_s6 == '0) begin
			drop_s6 = sbb_pkg::HEIGHT_W'(1);
		end
		if (bar_s6 >= ctx_s6.ent.peak) begin
			// A new peak: take the bar and restart the hold time.
			pk_next_s6   = bar_s6;
			hold_next_s6 = hold_frames_q;
		end else if (ctx_s6.ent.hold != '0) begin
			hold_next_s6 = ctx_s6.ent.hold - sbb_pkg::HOLD_W'(1);
		end else if (ctx_s6.ent.peak > drop_s6) begin
			pk_next_s6 = ctx_s6.ent.peak - drop_s6;
		end else begin
			pk_next_s6 = '0;
		end
	end

	assign pk_s6       = (pk_next_s6 > limit_q) ? limit_q : pk_next_s6;
	assign old_bar_s6  = (ctx_s6.ent.shown > limit_q) ? limit_q : ctx_s6.ent.shown;
	assign old_peak_s6 = (ctx_s6.ent.peak > limit_q) ? limit_q : ctx_s6.ent.peak;

	assign ram_wdata.smooth = snew_s6;
	assign ram_wdata.shown  = bar_s6;
	assign ram_wdata.peak   = pk_s6;
	assign ram_wdata.hold   = hold_next_s6;

	// ------------------------------------------------------------------
	// Pipeline control: valid bits of every stage and of the output register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			vld_s3      <= 1'b0;
			vld_s4      <= 1'b0;
			vld_s5      <= 1'b0;
			vld_s6      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_s1      <= accept;
			vld_s2      <= vld_s1;
			vld_s3      <= vld_s2;
			vld_s4      <= vld_s3;
			vld_s5      <= vld_s4;
			vld_s6      <= vld_s5;
			out_valid_q <= vld_s6;
		end
	end

	// Pipeline payload. It moves on the same condition as the valid bits.
	always_ff @(posedge clk) begin
		if (adv) begin
			band_s1    <= band_number;
			inr_s1     <= in_range;
			ent_vld_s1 <= in_range && valid_q[in_addr];
			level_s1   <= band_level;

			ctx_s2.band     <= band_s1;
			ctx_s2.in_range <= inr_s1;
			ctx_s2.ent      <= ent_s1;
			rise_s2         <= rising_s1;
			diff_s2         <= rising_s1 ? (target_s1 - ent_s1.smooth)
				: (ent_s1.smooth - target_s1);
			coef_s2         <= rising_s1 ? rise_q : fall_q;

			ctx_s3  <= ctx_s2;
			rise_s3 <= rise_s2;
			prod_s3 <= PROD_W'(diff_s2) * PROD_W'(coef_s2);

			ctx_s4  <= ctx_s3;
			snew_s4 <= rise_s3 ? (ctx_s3.ent.smooth + inc_s3) : (ctx_s3.ent.smooth - dec_s3);

			ctx_s5  <= ctx_s4;
			snew_s5 <= snew_s4;
			raw_s5  <= (raw8_s4 > {1'b0, limit_q}) ? limit_q : raw8_s4[sbb_pkg::HEIGHT_W-1:0];

			ctx_s6  <= ctx_s5;
			snew_s6 <= snew_s5;
			quot_s6 <= qprod_s5[RECIP_SH +: sbb_pkg::HEIGHT_W];

			// A band out of range reports zero heights and changes no state.
			result_band_q <= ctx_s6.band;
			bar_q         <= ctx_s6.in_range ? bar_s6 : '0;
			prior_bar_q   <= ctx_s6.in_range ? old_bar_s6 : '0;
			peak_q        <= ctx_s6.in_range ? pk_s6 : '0;
			prior_peak_q  <= ctx_s6.in_range ? old_peak_s6 : '0;
			moved_q       <= ctx_s6.in_range && (old_peak_s6 != '0) && (old_peak_s6 != pk_s6);
		end
	end

	assign out_valid         = out_valid_q;
	assign result_band       = result_band_q;
	assign bar_height        = bar_q;
	assign prior_bar_height  = prior_bar_q;
	assign peak_height       = peak_q;
	assign prior_peak_height = prior_peak_q;
	assign peak_moved        = moved_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// The interlock keeps a read from ever meeting a write to the same band.
	`SBB_ASSERT_NEVER(a_no_rw_collision, clk, arst_n, ram_we && ram_re && (ram_waddr == in_addr))
	// Reported heights never exceed the height limit.
	`SBB_ASSERT_IMPLIES(a_heights_limited, clk, arst_n, out_valid_q,
		(bar_q <= limit_q) && (peak_q <= limit_q) && (prior_peak_q <= limit_q))
	// A band out of range always reports an empty result.
	`SBB_ASSERT_IMPLIES(a_out_of_range_empty, clk, arst_n,
		out_valid_q && (32'(result_band_q) >= 32'(BAND_COUNT)),
		(bar_q == '0) && (peak_q == '0) && !moved_q)

endmodule

// ===== bench/spectrum_bar_ballistics_top_tb.sv =====
// Self-checking testbench for the spectrum bar ballistics block with random handshake stalls.
module spectrum_bar_ballistics_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BANDS       = sbb_pkg::BAND_COUNT_DEFAULT;
	localparam int PITCH       = sbb_pkg::BLOCK_PITCH_DEFAULT;
	localparam int RUN_LIMIT   = 200000;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 50;
	localparam int PLAN_ROWS   = 23;
	// Phase in which neither side idles, so the block runs at full rate except where a level waits for its band.
	localparam int STEADY_PHASE = 4;

	// One result transfer, field by field.
	typedef struct packed {
		logic [sbb_pkg::BAND_W-1:0]   band;
		logic [sbb_pkg::HEIGHT_W-1:0] bar;
		logic [sbb_pkg::HEIGHT_W-1:0] prior_bar;
		logic [sbb_pkg::HEIGHT_W-1:0] peak;
		logic [sbb_pkg::HEIGHT_W-1:0] prior_peak;
		logic                         moved;
	} bar_result_t;

	// A directed step is a level to send, a level whose result is typed in, or a register write.
	typedef enum logic [1:0] {
		ROW_ITEM,
		ROW_KNOWN,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t                       kind;
		sbb_pkg::cfg_idx_t               reg_sel;
		logic [sbb_pkg::CFG_DATA_W-1:0]  value;
		logic [sbb_pkg::BAND_W-1:0]      band;
		logic [sbb_pkg::LEVEL_W-1:0]     level;
		bar_result_t                     want;
	} plan_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [sbb_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [sbb_pkg::CFG_DATA_W-1:0]   cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_ready;
	logic [sbb_pkg::BAND_W-1:0]       band_number = '0;
	logic [sbb_pkg::LEVEL_W-1:0]      band_level = '0;
	logic                             out_valid;
	logic                             out_ready = 1'b0;
	logic [sbb_pkg::BAND_W-1:0]       result_band;
	logic [sbb_pkg::HEIGHT_W-1:0]     bar_height;
	logic [sbb_pkg::HEIGHT_W-1:0]     prior_bar_height;
	logic [sbb_pkg::HEIGHT_W-1:0]     peak_height;
	logic [sbb_pkg::HEIGHT_W-1:0]     prior_peak_height;
	logic                             peak_moved;

	// Both sides insert random idle cycles while this is set.
	bit idle_on = 1'b1;
	int mismatches = 0;
	int cycles = 0;

	// Results still owed by the block, oldest first.
	bar_result_t expected_bars[$];

	// Our own copy of the register file, at reset values.
	logic [sbb_pkg::COEF_W-1:0]   rise_coef   = sbb_pkg::RISE_RESET;
	logic [sbb_pkg::COEF_W-1:0]   fall_coef   = sbb_pkg::FALL_RESET;
	logic [sbb_pkg::HOLD_W-1:0]   hold_frames = sbb_pkg::HOLD_RESET;
	logic [sbb_pkg::HEIGHT_W-1:0] limit_px    = sbb_pkg::LIMIT_RESET;

	// Our own copy of the per-band state; everything starts at zero.
	logic [sbb_pkg::SMOOTH_W-1:0] smooth_q78 [BANDS];
	logic [sbb_pkg::HEIGHT_W-1:0] shown_px   [BANDS];
	logic [sbb_pkg::HEIGHT_W-1:0] peak_px    [BANDS];
	logic [sbb_pkg::HOLD_W-1:0]   hold_left  [BANDS];

	// Directed part. The first rows come straight out of reset, so their results are known:
	// a quiet band gives all zeros, and bands past the last column change nothing and report
	// zeros with the band echoed. Later rows push a bar to the top, lower the height limit
	// under it, let it fall with the fastest decay and no hold, and finally run a limit so
	// small that no whole block fits.
	plan_row_t directed_plan [PLAN_ROWS] = '{
		'{ROW_KNOWN, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd0, '{4'd0, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{ROW_KNOWN, sbb_pkg::CFG_RISE, 8'd0, 4'd15, 8'd255,
			'{4'd15, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{ROW_KNOWN, sbb_pkg::CFG_RISE, 8'd0, 4'd12, 8'd128,
			'{4'd12, 7'd0, 7'd0, 7'd0, 7'd0, 1'b0}},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd11, 8'd255, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd255, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd1, 8'd84, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd255, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd255, '0},
		'{ROW_WRITE, sbb_pkg::CFG_RISE, 8'd255, 4'd0, 8'd0, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd255, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd255, '0},
		'{ROW_WRITE, sbb_pkg::CFG_LIMIT, 8'd20, 4'd0, 8'd0, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd255, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd0, '0},
		'{ROW_WRITE, sbb_pkg::CFG_FALL, 8'd255, 4'd0, 8'd0, '0},
		'{ROW_WRITE, sbb_pkg::CFG_HOLD, 8'd0, 4'd0, 8'd0, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd0, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd0, 8'd0, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd11, 8'd0, '0},
		'{ROW_WRITE, sbb_pkg::CFG_LIMIT, 8'd3, 4'd0, 8'd0, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd1, 8'd255, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd2, 8'd1, '0},
		'{ROW_ITEM, sbb_pkg::CFG_RISE, 8'd0, 4'd10, 8'd128, '0}
	};

	spectrum_bar_ballistics_top u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.band_number       (band_number),
		.band_level        (band_level),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.result_band       (result_band),
		.bar_height        (bar_height),
		.prior_bar_height  (prior_bar_height),
		.peak_height       (peak_height),
		.prior_peak_height (prior_peak_height),
		.peak_moved        (peak_moved)
	);

	// 4 ns clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: a correct run finishes far below this many cycles.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Heights are clamped to the current limit wherever they are used or reported.
	function automatic logic [sbb_pkg::HEIGHT_W-1:0] fit_limit(input int unsigned v);
		return (v > limit_px) ? limit_px : sbb_pkg::HEIGHT_W'(v);
	endfunction

	// Advances one band's smoothing and peak hold, and returns the result it should give.
	function automatic bar_result_t step_band_meter(input logic [sbb_pkg::BAND_W-1:0] band,
			input logic [sbb_pkg::LEVEL_W-1:0] level);
		bar_result_t r;
		int unsigned target;
		int unsigned s;
		int unsigned bar;
		int unsigned pk;
		int unsigned drop;
		r = '0;
		r.band = band;
		// A band past the last column leaves every store alone.
		if (band >= BANDS)
			return r;
		target = int'(fit_limit(level)) << sbb_pkg::FRAC_W;
		s = smooth_q78[band];
		// Rising steps floor the product; falling steps floor toward minus infinity,
		// which is a ceiling on the size of the drop.
		if (target > s)
			s = s + (((target - s) * rise_coef) >> sbb_pkg::FRAC_W);
		else
			s = s - (((s - target) * fall_coef + 255) >> sbb_pkg::FRAC_W);
		smooth_q78[band] = sbb_pkg::SMOOTH_W'(s);
		bar = fit_limit((sbb_pkg::SMOOTH_W'(s) + 128) >> sbb_pkg::FRAC_W);
		bar = (bar / PITCH) * PITCH;
		r.bar = sbb_pkg::HEIGHT_W'(bar);
		r.prior_bar = fit_limit(shown_px[band]);
		r.prior_peak = fit_limit(peak_px[band]);
		pk = peak_px[band];
		if (bar >= pk) begin
			pk = bar;
			hold_left[band] = hold_frames;
		end else if (hold_left[band] != 0) begin
			hold_left[band] = hold_left[band] - 1'b1;
		end else begin
			// Once the hold is over the marker falls by a quarter of its gap, at least one.
			drop = (pk - bar) >> 2;
			if (drop < 1)
				drop = 1;
			pk = (pk > drop) ? pk - drop : 0;
		end
		r.peak = fit_limit(pk);
		peak_px[band] = r.peak;
		shown_px[band] = sbb_pkg::HEIGHT_W'(bar);
		r.moved = (r.prior_peak != 0) && (r.prior_peak != r.peak);
		return r;
	endfunction

	// Picks a level, weighted toward zero, full scale and the area around the limit.
	function automatic logic [sbb_pkg::LEVEL_W-1:0] draw_level();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: return sbb_pkg::LEVEL_W'(int'(limit_px) + int'($urandom_range(4)) - 2);
			default: return sbb_pkg::LEVEL_W'($urandom_range(255));
		endcase
	endfunction

	// Sends one band level. Payload changes on the falling edge; the transfer is taken at the
	// rising edge where ready is seen high, and the prediction is queued right then.
	task automatic drive_level(input logic [sbb_pkg::BAND_W-1:0] band,
			input logic [sbb_pkg::LEVEL_W-1:0] level, input bit known, input bar_result_t want);
		bar_result_t predicted;
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 21) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		band_number <= band;
		band_level <= level;
		do
			@(posedge clk);
		while (!in_ready);
		predicted = step_band_meter(band, level);
		expected_bars.push_back(known ? want : predicted);
	endtask

	// Register writes happen only with the pipeline drained: valid drops first, then every
	// owed result must have been seen. Every level yields a result, so an empty queue means
	// the block holds no work.
	task automatic write_reg(input sbb_pkg::cfg_idx_t sel,
			input logic [sbb_pkg::CFG_DATA_W-1:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bars.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (sel)
			sbb_pkg::CFG_RISE:  rise_coef = value;
			sbb_pkg::CFG_FALL:  fall_coef = value;
			sbb_pkg::CFG_HOLD:  hold_frames = value[sbb_pkg::HOLD_W-1:0];
			sbb_pkg::CFG_LIMIT: limit_px = value[sbb_pkg::HEIGHT_W-1:0];
			default: ;
		endcase
	endtask

	// The result side stalls at random too, except in the steady phase.
	always @(negedge clk) begin
		out_ready <= !idle_on || ($urandom_range(99) >= 21);
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		bar_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_bars.size() == 0) begin
				$error("result for band %0d arrived with nothing expected", result_band);
				mismatches++;
			end else begin
				want = expected_bars.pop_front();
				if (result_band !== want.band) begin
					$error("result_band: expected %0d, got %0d", want.band, result_band);
					mismatches++;
				end
				if (bar_height !== want.bar) begin
					$error("bar_height: expected %0d, got %0d", want.bar, bar_height);
					mismatches++;
				end
				if (prior_bar_height !== want.prior_bar) begin
					$error("prior_bar_height: expected %0d, got %0d", want.prior_bar,
						prior_bar_height);
					mismatches++;
				end
				if (peak_height !== want.peak) begin
					$error("peak_height: expected %0d, got %0d", want.peak, peak_height);
					mismatches++;
				end
				if (prior_peak_height !== want.prior_peak) begin
					$error("prior_peak_height: expected %0d, got %0d", want.prior_peak,
						prior_peak_height);
					mismatches++;
				end
				if (peak_moved !== want.moved) begin
					$error("peak_moved: expected %0d, got %0d", want.moved, peak_moved);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int sent;
		int burst_len;
		logic [sbb_pkg::BAND_W-1:0] band;
		logic [sbb_pkg::LEVEL_W-1:0] high;
		for (int i = 0; i < BANDS; i++) begin
			smooth_q78[i] = '0;
			shown_px[i] = '0;
			peak_px[i] = '0;
			hold_left[i] = '0;
		end

		// Reset is released on a falling edge.
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			case (directed_plan[i].kind)
				ROW_WRITE: write_reg(directed_plan[i].reg_sel, directed_plan[i].value);
				ROW_KNOWN: drive_level(directed_plan[i].band, directed_plan[i].level, 1'b1,
					directed_plan[i].want);
				default: drive_level(directed_plan[i].band, directed_plan[i].level, 1'b0, '0);
			endcase
		end

		// Random phases, each under its own register setting. The early ones take the
		// extremes: fastest and slowest smoothing, no hold and the longest hold, the full
		// height and the smallest limits, including a drop from the top limit to one block.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					write_reg(sbb_pkg::CFG_RISE, 8'd255);
					write_reg(sbb_pkg::CFG_FALL, 8'd255);
					write_reg(sbb_pkg::CFG_HOLD, 8'd0);
					write_reg(sbb_pkg::CFG_LIMIT, 8'd127);
				end
				1: begin
					write_reg(sbb_pkg::CFG_RISE, 8'd0);
					write_reg(sbb_pkg::CFG_FALL, 8'd0);
					write_reg(sbb_pkg::CFG_HOLD, 8'd15);
					write_reg(sbb_pkg::CFG_LIMIT, 8'd7);
				end
				2: begin
					write_reg(sbb_pkg::CFG_RISE, 8'd1);
					write_reg(sbb_pkg::CFG_FALL, 8'd1);
					write_reg(sbb_pkg::CFG_HOLD, 8'd15);
					write_reg(sbb_pkg::CFG_LIMIT, 8'd127);
				end
				STEADY_PHASE: begin
					write_reg(sbb_pkg::CFG_RISE, sbb_pkg::RISE_RESET);
					write_reg(sbb_pkg::CFG_FALL, sbb_pkg::FALL_RESET);
					write_reg(sbb_pkg::CFG_HOLD, sbb_pkg::CFG_DATA_W'(sbb_pkg::HOLD_RESET));
					write_reg(sbb_pkg::CFG_LIMIT, sbb_pkg::CFG_DATA_W'(sbb_pkg::LIMIT_RESET));
				end
				default: begin
					write_reg(sbb_pkg::CFG_RISE, sbb_pkg::CFG_DATA_W'($urandom_range(255)));
					write_reg(sbb_pkg::CFG_FALL, sbb_pkg::CFG_DATA_W'($urandom_range(255)));
					write_reg(sbb_pkg::CFG_HOLD, sbb_pkg::CFG_DATA_W'($urandom_range(15)));
					// Phases 3 and 5 run below one block; the rest from one block up to the full height.
					if (phase == 3)
						write_reg(sbb_pkg::CFG_LIMIT, 8'd0);
					else if (phase == 5)
						write_reg(sbb_pkg::CFG_LIMIT, sbb_pkg::CFG_DATA_W'($urandom_range(6)));
					else
						write_reg(sbb_pkg::CFG_LIMIT,
							sbb_pkg::CFG_DATA_W'($urandom_range(127, 7)));
				end
			endcase
			idle_on = (phase != STEADY_PHASE);

			sent = 0;
			while (sent < PHASE_ITEMS) begin
				if ($urandom_range(99) < 55) begin
					// A burst on one band: a loud stretch that lifts bar and peak, then
					// mostly silence so the hold can run out and the marker fall.
					band = sbb_pkg::BAND_W'($urandom_range(BANDS - 1));
					high = draw_level();
					burst_len = $urandom_range(16, 4);
					for (int k = 0; k < burst_len; k++) begin
						if (k < burst_len / 2)
							drive_level(band, high, 1'b0, '0);
						else
							drive_level(band, ($urandom_range(3) == 0) ? draw_level() : '0,
								1'b0, '0);
					end
					sent += burst_len;
				end else begin
					// A lone level, now and then for a column that does not exist.
					if ($urandom_range(99) < 15)
						band = sbb_pkg::BAND_W'($urandom_range(15, BANDS));
					else
						band = sbb_pkg::BAND_W'($urandom_range(BANDS - 1));
					drive_level(band, draw_level(), 1'b0, '0);
					sent++;
				end
			end
		end

		// Drain: drop valid, wait for every owed result, then watch a while for strays.
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_bars.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
